// ===== sv/assert_macros.svh =====
// Assertion helpers. Both sample on i_clk and stay off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or invariant.
`define TKS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Trigger in one cycle, check in the next.
`define TKS_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/tks_pkg.sv =====
`timescale 1ns / 1ps
package tks_pkg;

    localparam int VAL_W  = 40;
    localparam int SUM_W  = 42;
    localparam int IDX_W  = 10;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_A = 3'd0,
        MODE_LOAD_B = 3'd1,
        MODE_LOAD_C = 3'd2,
        MODE_POP    = 3'd3,
        MODE_CLEAR  = 3'd4
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_OVF   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LCHK,
        S_LCMP,
        S_TOP,
        S_TOPD,
        S_LAST,
        S_DL,
        S_DR,
        S_DC,
        S_SCAN,
        S_PUSH,
        S_SUM,
        S_UCHK,
        S_UCMP
    } t_state;

endpackage

// ===== sv/top_k_sums_three_sorted_lists_unit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Top-k three-way sums over three descending lists.
// Command channel: start/busy. A transaction is taken when start is high and busy
// is low; i_mode picks load A/B/C (i_value appended in sorted place), pop or clear.
// Result channel: o_valid strobes for one cycle with o_sum, o_index_a/b/c and
// o_status; the receiver cannot stall, so the result is simply presented once.
// Only pops give a result; loads, clear and unused modes give none.
// Throughput: one transaction at a time; start is ignored while busy is high.
// Sequence per command:
//   clear, unused mode, dropped load: done without raising busy.
//   load: the list RAM read/compare/write loop (S_LCHK, S_LCMP) walks the
//     insertion point down one entry per pass, then writes the new value.
//   pop: take the top and last frontier entries, sift-down (two child reads per
//     level on the single frontier RAM read port), one pass over the visited table
//     (all three neighbors checked per entry), then up to three pushes, each with
//     its sift-up.
//   Overflowed pop, or pop with an empty list: answered in the cycle after acceptance.
// One comparator ({sum, a, b, c} greater-than) is shared by every heap step.
// Reset: counts, frontier, visited fill and status flags clear at once; list and
// frontier storage is tracked by fill counts, so there is no clearing pass.
module top_k_sums_three_sorted_lists_unit #(
    parameter int MAX_LEN        = 1024,
    parameter int FRONTIER_DEPTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tks_pkg::MODE_W-1:0]  i_mode,
    input  logic [tks_pkg::VAL_W-1:0]   i_value,
    output logic                        o_valid,
    output logic [tks_pkg::SUM_W-1:0]   o_sum,
    output logic [tks_pkg::IDX_W-1:0]   o_index_a,
    output logic [tks_pkg::IDX_W-1:0]   o_index_b,
    output logic [tks_pkg::IDX_W-1:0]   o_index_c,
    output logic [tks_pkg::STAT_W-1:0]  o_status
);

    import tks_pkg::*;

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;   // list index
    localparam int LD = (MAX_LEN > 1) ? MAX_LEN : 2;           // list RAM depth
    localparam int CW = $clog2(MAX_LEN + 1);                   // list count
    localparam int AW = $clog2(FRONTIER_DEPTH);                // frontier address
    localparam int HW = $clog2(FRONTIER_DEPTH + 1);            // frontier count
    localparam int PW = AW + 2;                                // child index math
    localparam int TW = 3 * IW;                                // packed triple
    localparam int EW = SUM_W + TW;                            // heap entry

    // state
    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b, r_cnt_c, n_cnt_c;
    logic [HW-1:0]     r_hcnt, n_hcnt, r_vcnt, n_vcnt, r_vi, n_vi;
    logic              r_popping, n_popping, r_ovf, n_ovf, r_seed, n_seed;
    logic              r_vval, n_vval, r_lbest, n_lbest;
    t_mode             r_sel, n_sel;
    logic [CW-1:0]     r_lpos, n_lpos;
    logic [AW-1:0]     r_hpos, n_hpos;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [EW-1:0]     r_x, n_x, r_ch, n_ch;
    logic [TW-1:0]     r_cur, n_cur;
    logic [SUM_W-1:0]  r_csum, n_csum;
    logic [1:0]        r_d, n_d;
    logic [2:0]        r_seen, n_seen;
    logic              r_ovalid, n_ovalid;
    logic [SUM_W-1:0]  r_osum, n_osum;
    logic [IDX_W-1:0]  r_oia, n_oia, r_oib, n_oib, r_oic, n_oic;
    t_status           r_ostat, n_ostat;

    // RAM ports
    logic              w_lwe;
    logic [IW-1:0]     w_lwaddr;
    logic [VAL_W-1:0]  w_lwdata;
    logic [IW-1:0]     w_raddr_a, w_raddr_b, w_raddr_c;
    logic [VAL_W-1:0]  w_rd_a, w_rd_b, w_rd_c, w_rd_sel;
    logic              w_hwe;
    logic [AW-1:0]     w_hwaddr, w_hraddr;
    logic [EW-1:0]     w_hwdata, w_hrd;
    logic              w_vwe;
    logic [TW-1:0]     w_vrd;

    // datapath helpers
    logic [IW-1:0]     w_ca, w_cb, w_cc;
    logic [TW-1:0]     w_n0, w_n1, w_n2, w_nxt;
    logic [PW-1:0]     w_l, w_r, w_hcnt_x;
    logic [AW-1:0]     w_par;
    logic [SUM_W-1:0]  w_sum;
    logic [EW-1:0]     w_cmp_x, w_cmp_y;
    logic              w_above, w_seen_d;
    logic [IW-1:0]     w_ta, w_tb, w_tc;

    tks_ram #(.W(VAL_W), .D(LD)) u_list_a (
        .i_clk(i_clk), .i_we(w_lwe && r_sel == MODE_LOAD_A), .i_waddr(w_lwaddr),
        .i_wdata(w_lwdata), .i_raddr(w_raddr_a), .o_rdata(w_rd_a)
    );
    tks_ram #(.W(VAL_W), .D(LD)) u_list_b (
        .i_clk(i_clk), .i_we(w_lwe && r_sel == MODE_LOAD_B), .i_waddr(w_lwaddr),
        .i_wdata(w_lwdata), .i_raddr(w_raddr_b), .o_rdata(w_rd_b)
    );
    tks_ram #(.W(VAL_W), .D(LD)) u_list_c (
        .i_clk(i_clk), .i_we(w_lwe && r_sel == MODE_LOAD_C), .i_waddr(w_lwaddr),
        .i_wdata(w_lwdata), .i_raddr(w_raddr_c), .o_rdata(w_rd_c)
    );
    tks_ram #(.W(EW), .D(FRONTIER_DEPTH)) u_heap (
        .i_clk(i_clk), .i_we(w_hwe), .i_waddr(w_hwaddr), .i_wdata(w_hwdata),
        .i_raddr(w_hraddr), .o_rdata(w_hrd)
    );
    tks_ram #(.W(TW), .D(FRONTIER_DEPTH)) u_visited (
        .i_clk(i_clk), .i_we(w_vwe), .i_waddr(r_vcnt[AW-1:0]), .i_wdata(w_nxt),
        .i_raddr(r_vi[AW-1:0]), .o_rdata(w_vrd)
    );

    // triple layout {a, b, c}, a most significant: entry compare is one magnitude
    // compare of {sum, a, b, c}
    assign w_ca = r_cur[TW-1:2*IW];
    assign w_cb = r_cur[2*IW-1:IW];
    assign w_cc = r_cur[IW-1:0];
    assign w_n0 = {w_ca + IW'(1), w_cb, w_cc};
    assign w_n1 = {w_ca, w_cb + IW'(1), w_cc};
    assign w_n2 = {w_ca, w_cb, w_cc + IW'(1)};

    always_comb begin
        case (r_d)
            2'd0:    w_nxt = w_n0;
            2'd1:    w_nxt = w_n1;
            2'd2:    w_nxt = w_n2;
            default: w_nxt = r_cur;
        endcase
        if (r_seed) begin
            w_nxt = r_cur;
        end
        case (r_d)
            2'd0:    w_seen_d = r_seen[0];
            2'd1:    w_seen_d = r_seen[1];
            2'd2:    w_seen_d = r_seen[2];
            default: w_seen_d = 1'b1;
        endcase
        case (r_sel)
            MODE_LOAD_A: w_rd_sel = w_rd_a;
            MODE_LOAD_B: w_rd_sel = w_rd_b;
            default:     w_rd_sel = w_rd_c;
        endcase
    end

    assign w_ta     = w_hrd[TW-1:2*IW];
    assign w_tb     = w_hrd[2*IW-1:IW];
    assign w_tc     = w_hrd[IW-1:0];
    assign w_l      = {1'b0, r_hpos, 1'b1};
    assign w_r      = w_l + PW'(1);
    assign w_hcnt_x = PW'(r_hcnt);
    assign w_par    = (r_hpos - AW'(1)) >> 1;
    assign w_sum    = SUM_W'(w_rd_a) + SUM_W'(w_rd_b) + SUM_W'(w_rd_c);

    // list reads: neighbor lookup while pushing, insertion walk otherwise
    assign w_raddr_a = (r_state == S_PUSH) ? w_nxt[TW-1:2*IW]  : IW'(r_lpos - CW'(1));
    assign w_raddr_b = (r_state == S_PUSH) ? w_nxt[2*IW-1:IW] : IW'(r_lpos - CW'(1));
    assign w_raddr_c = (r_state == S_PUSH) ? w_nxt[IW-1:0]    : IW'(r_lpos - CW'(1));
    assign w_lwaddr  = IW'(r_lpos);

    // shared ranking comparator
    always_comb begin
        case (r_state)
            S_DR: begin
                w_cmp_x = w_hrd;
                w_cmp_y = r_x;
            end
            S_DC: begin
                w_cmp_x = w_hrd;
                w_cmp_y = r_lbest ? r_ch : r_x;
            end
            default: begin
                w_cmp_x = r_x;
                w_cmp_y = w_hrd;
            end
        endcase
    end
    assign w_above = w_cmp_x > w_cmp_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_cnt_c   <= '0;
            r_hcnt    <= '0;
            r_vcnt    <= '0;
            r_popping <= 1'b0;
            r_ovf     <= 1'b0;
            r_seed    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_a   <= n_cnt_a;
            r_cnt_b   <= n_cnt_b;
            r_cnt_c   <= n_cnt_c;
            r_hcnt    <= n_hcnt;
            r_vcnt    <= n_vcnt;
            r_popping <= n_popping;
            r_ovf     <= n_ovf;
            r_seed    <= n_seed;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vi    <= n_vi;
        r_vval  <= n_vval;
        r_lbest <= n_lbest;
        r_sel   <= n_sel;
        r_lpos  <= n_lpos;
        r_hpos  <= n_hpos;
        r_val   <= n_val;
        r_x     <= n_x;
        r_ch    <= n_ch;
        r_cur   <= n_cur;
        r_csum  <= n_csum;
        r_d     <= n_d;
        r_seen  <= n_seen;
        r_osum  <= n_osum;
        r_oia   <= n_oia;
        r_oib   <= n_oib;
        r_oic   <= n_oic;
        r_ostat <= n_ostat;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;
        n_cnt_c   = r_cnt_c;
        n_hcnt    = r_hcnt;
        n_vcnt    = r_vcnt;
        n_vi      = r_vi;
        n_popping = r_popping;
        n_ovf     = r_ovf;
        n_seed    = r_seed;
        n_vval    = r_vval;
        n_lbest   = r_lbest;
        n_sel     = r_sel;
        n_lpos    = r_lpos;
        n_hpos    = r_hpos;
        n_val     = r_val;
        n_x       = r_x;
        n_ch      = r_ch;
        n_cur     = r_cur;
        n_csum    = r_csum;
        n_d       = r_d;
        n_seen    = r_seen;
        n_ovalid  = 1'b0;
        n_osum    = '0;
        n_oia     = '0;
        n_oib     = '0;
        n_oic     = '0;
        n_ostat   = STAT_EMPTY;
        w_lwe     = 1'b0;
        w_lwdata  = r_val;
        w_hwe     = 1'b0;
        w_hwaddr  = r_hpos;
        w_hwdata  = r_x;
        w_hraddr  = '0;
        w_vwe     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_mode)
                        MODE_LOAD_A, MODE_LOAD_B, MODE_LOAD_C: begin
                            n_sel = t_mode'(i_mode);
                            n_val = i_value;
                            case (t_mode'(i_mode))
                                MODE_LOAD_A: n_lpos = r_cnt_a;
                                MODE_LOAD_B: n_lpos = r_cnt_b;
                                default:     n_lpos = r_cnt_c;
                            endcase
                            if (!r_popping && n_lpos < CW'(MAX_LEN)) begin
                                n_state = S_LCHK;
                            end
                        end
                        MODE_POP: begin
                            if (r_ovf) begin
                                n_ovalid = 1'b1;
                                n_ostat  = STAT_OVF;
                            end else if (r_cnt_a == '0 || r_cnt_b == '0
                                         || r_cnt_c == '0) begin
                                n_ovalid = 1'b1;
                                n_ostat  = STAT_EMPTY;
                            end else if (!r_popping) begin
                                // first pop seeds the frontier with (0,0,0)
                                n_popping = 1'b1;
                                n_seed    = 1'b1;
                                n_cur     = '0;
                                n_seen    = '0;
                                n_d       = '0;
                                n_state   = S_PUSH;
                            end else begin
                                n_state = S_TOP;
                            end
                        end
                        MODE_CLEAR: begin
                            n_cnt_a   = '0;
                            n_cnt_b   = '0;
                            n_cnt_c   = '0;
                            n_hcnt    = '0;
                            n_vcnt    = '0;
                            n_popping = 1'b0;
                            n_ovf     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // insertion walk: move smaller entries up one slot
            S_LCHK: begin
                if (r_lpos == '0) begin
                    w_lwe   = 1'b1;
                    n_state = S_IDLE;
                    case (r_sel)
                        MODE_LOAD_A: n_cnt_a = r_cnt_a + CW'(1);
                        MODE_LOAD_B: n_cnt_b = r_cnt_b + CW'(1);
                        default:     n_cnt_c = r_cnt_c + CW'(1);
                    endcase
                end else begin
                    n_state = S_LCMP;
                end
            end
            S_LCMP: begin
                w_lwe = 1'b1;
                if (w_rd_sel < r_val) begin
                    w_lwdata = w_rd_sel;
                    n_lpos   = r_lpos - CW'(1);
                    n_state  = S_LCHK;
                end else begin
                    n_state = S_IDLE;
                    case (r_sel)
                        MODE_LOAD_A: n_cnt_a = r_cnt_a + CW'(1);
                        MODE_LOAD_B: n_cnt_b = r_cnt_b + CW'(1);
                        default:     n_cnt_c = r_cnt_c + CW'(1);
                    endcase
                end
            end

            S_TOP: begin
                if (r_hcnt == '0) begin
                    n_ovalid = 1'b1;
                    n_ostat  = STAT_EMPTY;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_TOPD;
                end
            end
            S_TOPD: begin
                n_csum    = w_hrd[EW-1:TW];
                n_cur     = w_hrd[TW-1:0];
                n_seen[0] = (CW'(w_ta) + CW'(1)) >= r_cnt_a;
                n_seen[1] = (CW'(w_tb) + CW'(1)) >= r_cnt_b;
                n_seen[2] = (CW'(w_tc) + CW'(1)) >= r_cnt_c;
                n_vi      = '0;
                n_vval    = 1'b0;
                n_hcnt    = r_hcnt - HW'(1);
                if (r_hcnt == HW'(1)) begin
                    n_state = S_SCAN;
                end else begin
                    w_hraddr = AW'(r_hcnt - HW'(1));
                    n_state  = S_LAST;
                end
            end
            S_LAST: begin
                n_x     = w_hrd;
                n_hpos  = '0;
                n_state = S_DL;
            end

            // sift-down with the moved entry held in r_x
            S_DL: begin
                if (w_l < w_hcnt_x) begin
                    w_hraddr = w_l[AW-1:0];
                    n_state  = S_DR;
                end else begin
                    w_hwe   = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_DR: begin
                n_ch    = w_hrd;
                n_lbest = w_above;
                if (w_r < w_hcnt_x) begin
                    w_hraddr = w_r[AW-1:0];
                    n_state  = S_DC;
                end else if (w_above) begin
                    w_hwe    = 1'b1;
                    w_hwdata = w_hrd;
                    n_hpos   = w_l[AW-1:0];
                    n_state  = S_DL;
                end else begin
                    w_hwe   = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_DC: begin
                w_hwe = 1'b1;
                if (w_above) begin
                    w_hwdata = w_hrd;
                    n_hpos   = w_r[AW-1:0];
                    n_state  = S_DL;
                end else if (r_lbest) begin
                    w_hwdata = r_ch;
                    n_hpos   = w_l[AW-1:0];
                    n_state  = S_DL;
                end else begin
                    n_state = S_SCAN;
                end
            end

            // one pass over the visited table checks all three neighbors
            S_SCAN: begin
                n_vval = r_vi < r_vcnt;
                if (r_vi < r_vcnt) begin
                    n_vi = r_vi + HW'(1);
                end
                if (r_vval) begin
                    n_seen[0] = r_seen[0] || (w_vrd == w_n0);
                    n_seen[1] = r_seen[1] || (w_vrd == w_n1);
                    n_seen[2] = r_seen[2] || (w_vrd == w_n2);
                end
                if (!(r_vi < r_vcnt) && !r_vval) begin
                    n_d     = '0;
                    n_state = S_PUSH;
                end
            end

            S_PUSH: begin
                if (!r_seed && r_d == 2'd3) begin
                    n_ovalid = 1'b1;
                    n_ostat  = STAT_OK;
                    n_osum   = r_csum;
                    n_oia    = IDX_W'(w_ca);
                    n_oib    = IDX_W'(w_cb);
                    n_oic    = IDX_W'(w_cc);
                    n_state  = S_IDLE;
                end else if (!r_seed && w_seen_d) begin
                    n_d = r_d + 2'd1;
                end else if (r_hcnt >= HW'(FRONTIER_DEPTH)
                             || r_vcnt >= HW'(FRONTIER_DEPTH)) begin
                    // dropped push; this pop still reports its sum
                    n_ovf = 1'b1;
                    n_d   = r_d + 2'd1;
                end else begin
                    w_vwe   = 1'b1;
                    n_vcnt  = r_vcnt + HW'(1);
                    n_x     = {SUM_W'(0), w_nxt};
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_x     = {w_sum, r_x[TW-1:0]};
                n_hpos  = AW'(r_hcnt);
                n_hcnt  = r_hcnt + HW'(1);
                n_state = S_UCHK;
            end

            // sift-up, hole method
            S_UCHK: begin
                if (r_hpos == '0) begin
                    w_hwe = 1'b1;
                    if (r_seed) begin
                        n_seed  = 1'b0;
                        n_state = S_TOP;
                    end else begin
                        n_d     = r_d + 2'd1;
                        n_state = S_PUSH;
                    end
                end else begin
                    w_hraddr = w_par;
                    n_state  = S_UCMP;
                end
            end
            S_UCMP: begin
                w_hwe = 1'b1;
                if (w_above) begin
                    w_hwdata = w_hrd;
                    n_hpos   = w_par;
                    n_state  = S_UCHK;
                end else if (r_seed) begin
                    n_seed  = 1'b0;
                    n_state = S_TOP;
                end else begin
                    n_d     = r_d + 2'd1;
                    n_state = S_PUSH;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_sum     = r_osum;
    assign o_index_a = r_oia;
    assign o_index_b = r_oib;
    assign o_index_c = r_oic;
    assign o_status  = r_ostat;

    `TKS_ASSERT(a_heap_le_visited, r_hcnt <= r_vcnt, "frontier larger than visited table")
    `TKS_ASSERT(a_result_when_idle, r_ovalid |-> !busy, "result strobed while busy")
    `TKS_ASSERT(a_fail_zero, (r_ovalid && r_ostat != STAT_OK) |-> (r_osum == '0 && r_oia == '0 && r_oib == '0 && r_oic == '0), "nonzero fields on failed pop")
    `TKS_ASSERT(a_list_cnt_max, r_cnt_a <= CW'(MAX_LEN) && r_cnt_b <= CW'(MAX_LEN) && r_cnt_c <= CW'(MAX_LEN), "list count past limit")
    `TKS_ASSERT_NEXT(a_clear_empties, start && !busy && i_mode == MODE_CLEAR, r_hcnt == '0 && r_vcnt == '0 && !r_ovf && !r_popping, "clear left state behind")

endmodule

// ===== sv/tks_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read per cycle.
module tks_ram #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
